@@ rtl/core/sha256_stream_hasher_assert.svh @@
// Assertion macros for the SHA-256 stream hasher checker.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// property checked on every clock edge outside reset
`define SHS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("shs assertion failed");

// implication whose consequent is checked in the following cycle
`define SHS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("shs assertion failed");

`endif

@@ rtl/core/shs_pkg.sv @@
// Shared types, constants and SHA-256 tables for the stream hasher.
// No dependencies.
package shs_pkg;

  localparam int CONTEXTS    = 2;
  localparam int CTX_W       = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int BLOCK_BYTES = 64;
  localparam int BLOCK_WORDS = BLOCK_BYTES / 4;
  localparam int LEN_POS     = BLOCK_BYTES - 8;
  localparam int BUF_WORDS   = CONTEXTS * BLOCK_WORDS;
  localparam int BUF_AW      = $clog2(BUF_WORDS);
  localparam int COUNT_W     = 61;
  localparam int ROUNDS      = 64;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DISPATCH, ST_LOAD, ST_ROUND, ST_ADD, ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_DATA, PH_PAD_A, PH_PAD_B
  } phase_e;

  typedef struct packed {
    logic       accept;
    logic       init_wv;
    logic       rd_en;
    logic [3:0] word;
    logic       ld_shift;
    logic       round_en;
    logic [5:0] round_idx;
    logic       cv_add;
    logic       out_load;
    logic       all_data;
    logic       mark;
    logic       len;
  } cmd_t;

  typedef struct packed {
    logic       blk_full;
    logic       msg_end;
    logic [5:0] fill;
    logic       out_busy;
  } sts_t;

  function automatic word_t iv_word(input logic [2:0] idx);
    word_t r;
    unique case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    word_t r;
    unique case (t)
      6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491; 6'd2:  r = 32'hb5c0fbcf;
      6'd3:  r = 32'he9b5dba5; 6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5; 6'd8:  r = 32'hd807aa98;
      6'd9:  r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/shs_if.sv @@
// Valid/ready channel interfaces for the SHA-256 stream hasher.
// Depends on shs_pkg for the context width.
interface shs_in_if import shs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CTX_W-1:0] context_select;
  logic [7:0]       data_byte;
  logic             has_data;
  logic             message_end;

  modport source (output valid, context_select, data_byte, has_data, message_end,
                  input ready);
  modport sink   (input valid, context_select, data_byte, has_data, message_end,
                  output ready);
endinterface

interface shs_out_if import shs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CTX_W-1:0] digest_context;
  logic [63:0]      digest_bits_255_192;
  logic [63:0]      digest_bits_191_128;
  logic [63:0]      digest_bits_127_64;
  logic [63:0]      digest_bits_63_0;

  modport source (output valid, digest_context, digest_bits_255_192, digest_bits_191_128,
                  digest_bits_127_64, digest_bits_63_0, input ready);
  modport sink   (input valid, digest_context, digest_bits_255_192, digest_bits_191_128,
                  digest_bits_127_64, digest_bits_63_0, output ready);
endinterface

@@ rtl/core/shs_ctrl.sv @@
// Sequencer for the stream hasher: item dispatch, block load, rounds, chaining add, padding, digest hand-off.
// Depends on shs_pkg.
module shs_ctrl import shs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e     state_q, state_d;
  phase_e     phase_q, phase_d;
  logic [5:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_DATA;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;

    // block content selection for the loader
    unique case (phase_q)
      PH_DATA: begin
        cmd_o.all_data = 1'b1;
      end
      PH_PAD_A: begin
        cmd_o.mark = 1'b1;
        cmd_o.len  = (sts_i.fill <= 6'(LEN_POS - 1));
      end
      default: begin
        cmd_o.len = 1'b1;
      end
    endcase

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        step_d = '0;
        if (sts_i.blk_full) begin
          phase_d = PH_DATA;
          state_d = ST_LOAD;
        end else if (sts_i.msg_end) begin
          phase_d = PH_PAD_A;
          state_d = ST_LOAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_LOAD: begin
        // read word n while shifting in word n-1
        cmd_o.rd_en    = (step_q < 6'(BLOCK_WORDS));
        cmd_o.word     = step_q[3:0];
        cmd_o.ld_shift = (step_q != '0);
        cmd_o.init_wv  = (step_q == '0);
        step_d         = step_q + 6'd1;
        if (step_q == 6'(BLOCK_WORDS)) begin
          step_d  = '0;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd_o.round_en  = 1'b1;
        cmd_o.round_idx = step_q;
        step_d          = step_q + 6'd1;
        if (step_q == 6'(ROUNDS - 1)) state_d = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.cv_add = 1'b1;
        step_d       = '0;
        unique case (phase_q)
          PH_DATA: begin
            if (sts_i.msg_end) begin
              phase_d = PH_PAD_A;
              state_d = ST_LOAD;
            end else begin
              state_d = ST_IDLE;
            end
          end
          PH_PAD_A: begin
            if (cmd_o.len) begin
              state_d = ST_OUT;
            end else begin
              phase_d = PH_PAD_B;
              state_d = ST_LOAD;
            end
          end
          default: begin
            state_d = ST_OUT;
          end
        endcase
      end
      ST_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/shs_datapath.sv @@
// Datapath: block buffer memory, per-context state, schedule window and rounds.
// Depends on shs_pkg.
module shs_datapath import shs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CTX_W-1:0] in_ctx_i,
  input  logic [7:0]       in_byte_i,
  input  logic             in_has_i,
  input  logic             in_end_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [CTX_W-1:0] out_ctx_o,
  output logic [63:0]      out_d0_o,
  output logic [63:0]      out_d1_o,
  output logic [63:0]      out_d2_o,
  output logic [63:0]      out_d3_o
);

  word_t              buf_mem [BUF_WORDS];
  word_t              rdata_q;
  logic [3:0]         rdidx_q;

  word_t              cv_q    [CONTEXTS][8];
  logic [5:0]         fill_q  [CONTEXTS];
  logic [COUNT_W-1:0] count_q [CONTEXTS];

  logic [CTX_W-1:0]   ctx_q;
  logic               blk_full_q;
  logic               msg_end_q;

  word_t              win_q [BLOCK_WORDS];
  word_t              wv_q  [8];

  logic               out_valid_q;
  logic [CTX_W-1:0]   out_ctx_q;
  logic [63:0]        out_d_q [4];

  logic [5:0]         cur_fill;
  logic [63:0]        len_bits;
  word_t              ld_word;
  word_t              sched_new;
  word_t              t1, t2;

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  assign cur_fill = fill_q[ctx_q];
  assign len_bits = {count_q[ctx_q], 3'b000};

  // byte substitution for padding blocks
  always_comb begin
    logic [5:0] p;
    ld_word = '0;
    for (int j = 0; j < 4; j++) begin
      p = {rdidx_q, 2'(j)};
      if (cmd_i.all_data || (cmd_i.mark && p < cur_fill)) begin
        ld_word[8*(3-j) +: 8] = rdata_q[8*(3-j) +: 8];
      end else if (cmd_i.mark && p == cur_fill) begin
        ld_word[8*(3-j) +: 8] = PAD_BYTE;
      end else if (cmd_i.len && p >= 6'(LEN_POS)) begin
        ld_word[8*(3-j) +: 8] = len_bits[8*(7-int'(p[2:0])) +: 8];
      end
    end
  end

  always_comb begin
    word_t x2, x15;
    x2        = win_q[14];
    x15       = win_q[1];
    sched_new = (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10)) + win_q[9] +
                (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3)) + win_q[0];
  end

  always_comb begin
    word_t a, e;
    a  = wv_q[0];
    e  = wv_q[4];
    t1 = wv_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
         ((e & wv_q[5]) ^ (~e & wv_q[6])) + round_k(cmd_i.round_idx) + win_q[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
         ((a & wv_q[1]) ^ (a & wv_q[2]) ^ (wv_q[1] & wv_q[2]));
  end

  // block buffer: byte writes on accept, word reads while loading
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && in_has_i) begin
      buf_mem[{in_ctx_i, fill_q[in_ctx_i][5:2]}][8*(3-int'(fill_q[in_ctx_i][1:0])) +: 8]
        <= in_byte_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= buf_mem[{ctx_q, cmd_i.word}];
    end
    // index of the word now held in rdata_q
    rdidx_q <= cmd_i.word;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ctx_q      <= in_ctx_i;
      msg_end_q  <= in_end_i;
      blk_full_q <= in_has_i && (fill_q[in_ctx_i] == 6'(BLOCK_BYTES - 1));
    end
    if (cmd_i.ld_shift || cmd_i.round_en) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) win_q[i] <= win_q[i+1];
      win_q[BLOCK_WORDS-1] <= cmd_i.ld_shift ? ld_word : sched_new;
    end
    if (cmd_i.init_wv) begin
      for (int i = 0; i < 8; i++) wv_q[i] <= cv_q[ctx_q][i];
    end else if (cmd_i.round_en) begin
      wv_q[7] <= wv_q[6];
      wv_q[6] <= wv_q[5];
      wv_q[5] <= wv_q[4];
      wv_q[4] <= wv_q[3] + t1;
      wv_q[3] <= wv_q[2];
      wv_q[2] <= wv_q[1];
      wv_q[1] <= wv_q[0];
      wv_q[0] <= t1 + t2;
    end
    if (cmd_i.out_load) begin
      out_ctx_q <= ctx_q;
      for (int i = 0; i < 4; i++) out_d_q[i] <= {cv_q[ctx_q][2*i], cv_q[ctx_q][2*i+1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CONTEXTS; c++) begin
        for (int i = 0; i < 8; i++) cv_q[c][i] <= iv_word(3'(i));
        fill_q[c]  <= '0;
        count_q[c] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept && in_has_i) begin
        fill_q[in_ctx_i]  <= fill_q[in_ctx_i] + 6'd1;
        count_q[in_ctx_i] <= count_q[in_ctx_i] + COUNT_W'(1);
      end
      if (cmd_i.cv_add) begin
        for (int i = 0; i < 8; i++) cv_q[ctx_q][i] <= cv_q[ctx_q][i] + wv_q[i];
      end
      if (cmd_i.out_load) begin
        // context restarts once its digest is captured
        for (int i = 0; i < 8; i++) cv_q[ctx_q][i] <= iv_word(3'(i));
        fill_q[ctx_q]  <= '0;
        count_q[ctx_q] <= '0;
        out_valid_q    <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.blk_full = blk_full_q;
  assign sts_o.msg_end  = msg_end_q;
  assign sts_o.fill     = cur_fill;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_ctx_o   = out_ctx_q;
  assign out_d0_o    = out_d_q[0];
  assign out_d1_o    = out_d_q[1];
  assign out_d2_o    = out_d_q[2];
  assign out_d3_o    = out_d_q[3];

endmodule

@@ rtl/core/sha256_stream_hasher.sv @@
// SHA-256 stream hasher, two contexts, one byte per beat.
// A plain byte beat passes through the idle and dispatch states; a beat that fills a block
// adds one compression (block load, rounds, chaining add), all on one round unit.
// A closing beat adds one or two compressions and a digest hand-off that can wait.
// Reset is asynchronous, active low: every context restarts from the initial hash.
module sha256_stream_hasher import shs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  shs_in_if.sink    in_i,
  shs_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  shs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  shs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ctx_i    (in_i.context_select),
    .in_byte_i   (in_i.data_byte),
    .in_has_i    (in_i.has_data),
    .in_end_i    (in_i.message_end),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_ctx_o   (out_o.digest_context),
    .out_d0_o    (out_o.digest_bits_255_192),
    .out_d1_o    (out_o.digest_bits_191_128),
    .out_d2_o    (out_o.digest_bits_127_64),
    .out_d3_o    (out_o.digest_bits_63_0)
  );

endmodule

@@ rtl/core/shs_checker.sv @@
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
// Depends on shs_pkg and sha256_stream_hasher_assert.svh.
`include "sha256_stream_hasher_assert.svh"

module shs_checker import shs_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [CTX_W-1:0] out_ctx_i,
  input logic [63:0]      out_d0_i
);

  `SHS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `SHS_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_ctx_i) && $stable(out_d0_i))
  `SHS_ASSERT_NEXT(a_busy_after_beat, in_valid_i && in_ready_i, !in_ready_i)
  `SHS_ASSERT(a_digest_while_busy, $rose(out_valid_i) |-> $past(!in_ready_i))

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_ctx_i   (out_o.digest_context),
  .out_d0_i    (out_o.digest_bits_255_192)
);
